/* rtl/awbs_pkg.sv */
// shared constants and types of the affine warp bilinear sampler
package awbs_pkg;

    // image and destination limits
    localparam int MAX_SRC_WIDTH  = 512;
    localparam int MAX_SRC_HEIGHT = 512;
    localparam int MAX_DST_DIM    = 1024;

    // field widths
    localparam int COEF_W     = 32;
    localparam int DIM_REG_W  = 10;
    localparam int SRC_COL_FW = 9;
    localparam int SRC_ROW_FW = 9;
    localparam int PIX_W      = 8;
    localparam int DST_FW     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_W     = 16;

    // input tdata layout, lowest field first
    localparam int OFS_SRC_ROW = SRC_COL_FW;
    localparam int OFS_PIX     = OFS_SRC_ROW + SRC_ROW_FW;
    localparam int OFS_DST_COL = OFS_PIX + PIX_W;
    localparam int OFS_DST_ROW = OFS_DST_COL + DST_FW;
    localparam int S_DATA_BITS = OFS_DST_ROW + DST_FW;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = PIX_W;

    // source store split into four parity banks
    localparam int COL_W      = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_W      = $clog2(MAX_SRC_HEIGHT);
    localparam int BANK_AW    = COL_W + ROW_W - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS  = 4;

    // datapath widths
    localparam int DIMX_W = $clog2(MAX_SRC_WIDTH + 1);
    localparam int DIMY_W = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int PROD_W = COEF_W + DST_FW + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int F_W    = PIX_W + FRAC_W;
    localparam int L1_W   = F_W + 3;
    localparam int ACC_W  = F_W + FRAC_W + 2;

    // register reset values
    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(65536);
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
    localparam logic [DIM_REG_W-1:0]     DIM_RST   = DIM_REG_W'(512);

    // item kinds
    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_COL_TO_X = 3'd0,
        REG_COEF_ROW_TO_X = 3'd1,
        REG_OFFSET_X      = 3'd2,
        REG_COEF_COL_TO_Y = 3'd3,
        REG_COEF_ROW_TO_Y = 3'd4,
        REG_OFFSET_Y      = 3'd5,
        REG_SOURCE_WIDTH  = 3'd6,
        REG_SOURCE_HEIGHT = 3'd7
    } t_reg_idx;

endpackage

/* rtl/awbs_ram.sv */
// generic simple dual-port ram with registered read
module awbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/affine_warp_bilinear_sampler_unit.sv */
// top level of the affine warp bilinear sampler
// Takes one item per clock while results are taken, write or sample, and presents each
// sample's result in the output register. The pipe holds six registers: the input
// capture, the four matrix products, the coordinate sums, the bank read, the horizontal
// blend and the vertical blend in the output register. Every stage moves each cycle while
// results are taken, so items can follow back to back. Stages advance one by one, so
// bubbles close up while the output waits. The source image sits in four parity banks of
// rams with registered read, one per column and row parity, so the four neighbours of a
// point come out of the four banks in the same cycle. Writes reach the banks in the same
// stage as sample reads, so every sample sees exactly the writes accepted before it. The
// image store is not cleared after reset; a pixel has to be written before it is sampled.
// Configuration writes are taken in any cycle and should only be made while no item is
// in flight.
module affine_warp_bilinear_sampler_unit import awbs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // src_col[8:0], src_row[17:9], pixel_in[25:18], dst_col[35:26], dst_row[45:36], zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // func
    input  logic                 i_s_tuser,
    // result channel
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // pixel_out[7:0]
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // outside
    output logic                 o_m_tuser,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    // configuration registers
    logic signed [COEF_W-1:0] r_coef_cx, r_coef_rx, r_offset_x;
    logic signed [COEF_W-1:0] r_coef_cy, r_coef_ry, r_offset_y;
    logic [DIM_REG_W-1:0]     r_src_width, r_src_height;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;
    logic en1, en2, en3, en4, en5, out_en;

    // stage 1 payload
    t_func             r_s1_func;
    logic              r_s1_wr_ok, r_s1_oob;
    logic [COL_W-1:0]  r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [DST_FW-1:0] r_s1_dcol, r_s1_drow;

    // stage 2 payload
    t_func                    r_s2_func;
    logic                     r_s2_wr_ok, r_s2_oob;
    logic [COL_W-1:0]         r_s2_col;
    logic [ROW_W-1:0]         r_s2_row;
    logic [PIX_W-1:0]         r_s2_pix;
    logic signed [PROD_W-1:0] r_s2_pxc, r_s2_pxr, r_s2_pyc, r_s2_pyr;
    logic signed [PROD_W-1:0] n_s2_pxc, n_s2_pxr, n_s2_pyc, n_s2_pyr;

    // stage 3 payload
    t_func                   r_s3_func;
    logic                    r_s3_wr_ok, r_s3_oob;
    logic [COL_W-1:0]        r_s3_col;
    logic [ROW_W-1:0]        r_s3_row;
    logic [PIX_W-1:0]        r_s3_pix;
    logic signed [SUM_W-1:0] r_s3_sx, r_s3_sy;

    // stage 4 payload, pixel data lives in the bank read registers
    logic              r_s4_outside, r_s4_ix0, r_s4_iy0;
    logic [FRAC_W-1:0] r_s4_fx, r_s4_fy;

    // stage 5 payload
    logic              r_s5_outside;
    logic [FRAC_W-1:0] r_s5_fy;
    logic [F_W-1:0]    r_s5_f1, r_s5_f2;

    // output register
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_outside;

    // input unpack
    logic [SRC_COL_FW-1:0] in_src_col;
    logic [SRC_ROW_FW-1:0] in_src_row;
    logic [PIX_W-1:0]      in_pix;
    logic [DST_FW-1:0]     in_dst_col, in_dst_row;

    assign in_src_col = i_s_tdata[SRC_COL_FW-1:0];
    assign in_src_row = i_s_tdata[OFS_SRC_ROW +: SRC_ROW_FW];
    assign in_pix     = i_s_tdata[OFS_PIX +: PIX_W];
    assign in_dst_col = i_s_tdata[OFS_DST_COL +: DST_FW];
    assign in_dst_row = i_s_tdata[OFS_DST_ROW +: DST_FW];

    // configuration register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_cx    <= COEF_ONE;
            r_coef_rx    <= COEF_ZERO;
            r_offset_x   <= COEF_ZERO;
            r_coef_cy    <= COEF_ZERO;
            r_coef_ry    <= COEF_ONE;
            r_offset_y   <= COEF_ZERO;
            r_src_width  <= DIM_RST;
            r_src_height <= DIM_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_COEF_COL_TO_X: r_coef_cx    <= i_cfg_data;
                REG_COEF_ROW_TO_X: r_coef_rx    <= i_cfg_data;
                REG_OFFSET_X:      r_offset_x   <= i_cfg_data;
                REG_COEF_COL_TO_Y: r_coef_cy    <= i_cfg_data;
                REG_COEF_ROW_TO_Y: r_coef_ry    <= i_cfg_data;
                REG_OFFSET_Y:      r_offset_y   <= i_cfg_data;
                REG_SOURCE_WIDTH:  r_src_width  <= i_cfg_data[DIM_REG_W-1:0];
                REG_SOURCE_HEIGHT: r_src_height <= i_cfg_data[DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate image size and form the Q28.16 upper bounds
    logic [DIMX_W-1:0]       src_w_c;
    logic [DIMY_W-1:0]       src_h_c;
    logic signed [SUM_W-1:0] lim_x, lim_y;

    always_comb begin
        if (r_src_width < DIM_REG_W'(2)) begin
            src_w_c = DIMX_W'(2);
        end else if (int'(r_src_width) > MAX_SRC_WIDTH) begin
            src_w_c = DIMX_W'(MAX_SRC_WIDTH);
        end else begin
            src_w_c = DIMX_W'(r_src_width);
        end
        if (r_src_height < DIM_REG_W'(2)) begin
            src_h_c = DIMY_W'(2);
        end else if (int'(r_src_height) > MAX_SRC_HEIGHT) begin
            src_h_c = DIMY_W'(MAX_SRC_HEIGHT);
        end else begin
            src_h_c = DIMY_W'(r_src_height);
        end
        lim_x = signed'(SUM_W'({src_w_c - DIMX_W'(1), {FRAC_W{1'b0}}}));
        lim_y = signed'(SUM_W'({src_h_c - DIMY_W'(1), {FRAC_W{1'b0}}}));
    end

    // stage enables; a stage moves when the next is free or moving, stage 3 also on a write
    assign out_en     = !r_out_valid || i_m_tready;
    assign en5        = !r_v5 || out_en;
    assign en4        = !r_v4 || en5;
    assign en3        = !r_v3 || (r_s3_func == FUNC_WRITE) || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_s_tready = en1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_s_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3 && (r_s3_func == FUNC_SAMPLE);
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
            if (out_en) begin
                r_out_valid <= r_v5;
            end
        end
    end

    // stage 1: capture the item
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_func  <= t_func'(i_s_tuser);
            r_s1_wr_ok <= (int'(in_src_col) < MAX_SRC_WIDTH) &&
                          (int'(in_src_row) < MAX_SRC_HEIGHT);
            r_s1_oob   <= (int'(in_dst_col) >= MAX_DST_DIM) ||
                          (int'(in_dst_row) >= MAX_DST_DIM);
            r_s1_col   <= COL_W'(in_src_col);
            r_s1_row   <= ROW_W'(in_src_row);
            r_s1_pix   <= in_pix;
            r_s1_dcol  <= in_dst_col;
            r_s1_drow  <= in_dst_row;
        end
    end

    // stage 2: the four matrix products
    always_comb begin
        n_s2_pxc = PROD_W'(r_coef_cx) * PROD_W'(signed'({1'b0, r_s1_dcol}));
        n_s2_pxr = PROD_W'(r_coef_rx) * PROD_W'(signed'({1'b0, r_s1_drow}));
        n_s2_pyc = PROD_W'(r_coef_cy) * PROD_W'(signed'({1'b0, r_s1_dcol}));
        n_s2_pyr = PROD_W'(r_coef_ry) * PROD_W'(signed'({1'b0, r_s1_drow}));
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_func  <= r_s1_func;
            r_s2_wr_ok <= r_s1_wr_ok;
            r_s2_oob   <= r_s1_oob;
            r_s2_col   <= r_s1_col;
            r_s2_row   <= r_s1_row;
            r_s2_pix   <= r_s1_pix;
            r_s2_pxc   <= n_s2_pxc;
            r_s2_pxr   <= n_s2_pxr;
            r_s2_pyc   <= n_s2_pyc;
            r_s2_pyr   <= n_s2_pyr;
        end
    end

    // stage 3: source coordinates
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_func  <= r_s2_func;
            r_s3_wr_ok <= r_s2_wr_ok;
            r_s3_oob   <= r_s2_oob;
            r_s3_col   <= r_s2_col;
            r_s3_row   <= r_s2_row;
            r_s3_pix   <= r_s2_pix;
            r_s3_sx    <= SUM_W'(r_s2_pxc) + SUM_W'(r_s2_pxr) + SUM_W'(r_offset_x);
            r_s3_sy    <= SUM_W'(r_s2_pyc) + SUM_W'(r_s2_pyr) + SUM_W'(r_offset_y);
        end
    end

    // bounds check, neighbour split and bank access
    logic                     s3_outside, wr_go, rd_go;
    logic [COL_W-1:0]         ix, ix_p1;
    logic [ROW_W-1:0]         iy, iy_p1;
    logic [1:0]               wr_bank;
    logic [BANK_AW-1:0]       wr_addr;
    logic [BANK_AW-1:0]       rd_addr [NUM_BANKS];
    logic [PIX_W-1:0]         rd_data [NUM_BANKS];

    always_comb begin
        s3_outside = r_s3_oob || r_s3_sx[SUM_W-1] || r_s3_sy[SUM_W-1] ||
                     (r_s3_sx > lim_x) || (r_s3_sy > lim_y);
        ix         = r_s3_sx[FRAC_W +: COL_W];
        iy         = r_s3_sy[FRAC_W +: ROW_W];
        // the far neighbour wraps only where its weight is zero
        ix_p1      = ix + COL_W'(1);
        iy_p1      = iy + ROW_W'(1);
        wr_go      = r_v3 && (r_s3_func == FUNC_WRITE) && r_s3_wr_ok;
        rd_go      = r_v3 && (r_s3_func == FUNC_SAMPLE) && en4;
        wr_bank    = {r_s3_row[0], r_s3_col[0]};
        wr_addr    = {r_s3_row[ROW_W-1:1], r_s3_col[COL_W-1:1]};
    end

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        localparam logic CB = 1'((b >> 0) & 1);
        localparam logic RB = 1'((b >> 1) & 1);

        // the neighbour of matching parity is either the point or the one after it
        assign rd_addr[b] = {(iy[0] == RB) ? iy[ROW_W-1:1] : iy_p1[ROW_W-1:1],
                             (ix[0] == CB) ? ix[COL_W-1:1] : ix_p1[COL_W-1:1]};

        awbs_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (wr_go && (wr_bank == 2'(b))),
            .i_waddr (wr_addr),
            .i_wdata (r_s3_pix),
            .i_re    (rd_go),
            .i_raddr (rd_addr[b]),
            .o_rdata (rd_data[b])
        );
    end

    // stage 4: fractions travel beside the bank reads
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_outside <= s3_outside;
            r_s4_ix0     <= ix[0];
            r_s4_iy0     <= iy[0];
            r_s4_fx      <= r_s3_sx[FRAC_W-1:0];
            r_s4_fy      <= r_s3_sy[FRAC_W-1:0];
        end
    end

    // horizontal blend of the two neighbour rows
    logic [PIX_W-1:0]       p00, p10, p01, p11;
    logic signed [PIX_W:0]  d_top, d_bot;
    logic signed [L1_W-1:0] l_top, l_bot;

    always_comb begin
        p00 = rd_data[{r_s4_iy0, r_s4_ix0}];
        p10 = rd_data[{r_s4_iy0, !r_s4_ix0}];
        p01 = rd_data[{!r_s4_iy0, r_s4_ix0}];
        p11 = rd_data[{!r_s4_iy0, !r_s4_ix0}];
        // neighbours of zero weight, or off the image, contribute nothing
        if (r_s4_outside) begin
            p00 = '0;
        end
        if (r_s4_outside || (r_s4_fx == '0)) begin
            p10 = '0;
        end
        if (r_s4_outside || (r_s4_fy == '0)) begin
            p01 = '0;
        end
        if (r_s4_outside || (r_s4_fx == '0) || (r_s4_fy == '0)) begin
            p11 = '0;
        end
        d_top = signed'({1'b0, p10}) - signed'({1'b0, p00});
        d_bot = signed'({1'b0, p11}) - signed'({1'b0, p01});
        l_top = signed'(L1_W'({p00, {FRAC_W{1'b0}}})) +
                L1_W'(signed'({1'b0, r_s4_fx})) * L1_W'(d_top);
        l_bot = signed'(L1_W'({p01, {FRAC_W{1'b0}}})) +
                L1_W'(signed'({1'b0, r_s4_fx})) * L1_W'(d_bot);
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_outside <= r_s4_outside;
            r_s5_fy      <= r_s4_fy;
            r_s5_f1      <= l_top[F_W-1:0];
            r_s5_f2      <= l_bot[F_W-1:0];
        end
    end

    // vertical blend and truncation to 8 bits
    logic signed [F_W:0]     d_vert;
    logic signed [ACC_W-1:0] acc;
    logic [PIX_W-1:0]        n_out_pix;

    always_comb begin
        d_vert    = signed'({1'b0, r_s5_f2}) - signed'({1'b0, r_s5_f1});
        acc       = signed'(ACC_W'({r_s5_f1, {FRAC_W{1'b0}}})) +
                    ACC_W'(signed'({1'b0, r_s5_fy})) * ACC_W'(d_vert);
        n_out_pix = r_s5_outside ? '0 : acc[2*FRAC_W +: PIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_pix     <= n_out_pix;
            r_out_outside <= r_s5_outside;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tuser  = r_out_outside;

endmodule

/* rtl/awbs_chk.sv */
// port-level checker of the affine warp bilinear sampler, bound to the top level
module awbs_chk import awbs_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic                 o_m_tuser
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a point off the image always reads as zero
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("outside result with nonzero pixel");

    // a stalled result holds its item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // with the result register free the pipe never refuses an item
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

endmodule

bind affine_warp_bilinear_sampler_unit awbs_chk u_awbs_chk (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the affine warp bilinear sampler unit
module tb_top;
    import awbs_pkg::*;

    localparam int     CYCLE_LIMIT = 600000;
    localparam int     DRAIN_SLACK = 12;
    localparam int     ITEM_TARGET = 1550;
    localparam int     PHASE_ITEMS = 150;
    localparam int     LONG_HOLD   = 400;
    localparam longint ONE_Q16     = 65536;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             outside;
    } t_warp_result;

    // flavors of random transform settings
    typedef enum int {
        PH_SMALL,
        PH_WIDE,
        PH_WILD,
        PH_EXTREME
    } t_phase_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0]    i_cfg_data;

    // predictor state: register copies and the source image
    logic [COEF_W-1:0] warp_regs   [8];
    logic [PIX_W-1:0]  src_img     [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
    bit                pix_written [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
    t_warp_result      warped_q    [$];

    // run bookkeeping
    int cycle_cnt;
    int err_cnt;
    int items_sent;
    int writes_sent;
    int samples_sent;
    int results_seen;
    int inside_seen;
    int transforms_loaded;
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;
    int sink_hold;

    affine_warp_bilinear_sampler_unit u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // size registers saturate into the supported range
    function automatic int sat_dim(input logic [DIM_REG_W-1:0] raw, input int max_dim);
        if (raw < 2)
            return 2;
        if (raw > max_dim)
            return max_dim;
        return int'(raw);
    endfunction

    // inverse map of a destination point; 0 when it lands off the source image
    function automatic bit map_to_source(input logic [DST_FW-1:0] dc, dr,
            output int x0, output int y0, output int x1, output int y1,
            output int fx, output int fy);
        longint sx, sy;
        int     w, h;
        x0 = 0;
        y0 = 0;
        x1 = 0;
        y1 = 0;
        fx = 0;
        fy = 0;
        w = sat_dim(warp_regs[REG_SOURCE_WIDTH][DIM_REG_W-1:0], MAX_SRC_WIDTH);
        h = sat_dim(warp_regs[REG_SOURCE_HEIGHT][DIM_REG_W-1:0], MAX_SRC_HEIGHT);
        if (int'(dc) >= MAX_DST_DIM || int'(dr) >= MAX_DST_DIM)
            return 1'b0;
        sx = longint'($signed(warp_regs[REG_COEF_COL_TO_X])) * longint'(dc)
           + longint'($signed(warp_regs[REG_COEF_ROW_TO_X])) * longint'(dr)
           + longint'($signed(warp_regs[REG_OFFSET_X]));
        sy = longint'($signed(warp_regs[REG_COEF_COL_TO_Y])) * longint'(dc)
           + longint'($signed(warp_regs[REG_COEF_ROW_TO_Y])) * longint'(dr)
           + longint'($signed(warp_regs[REG_OFFSET_Y]));
        if (sx < 0 || sy < 0 || sx > longint'(w - 1) * ONE_Q16
                || sy > longint'(h - 1) * ONE_Q16)
            return 1'b0;
        x0 = int'(sx >>> FRAC_W);
        y0 = int'(sy >>> FRAC_W);
        fx = int'(sx & (ONE_Q16 - 1));
        fy = int'(sy & (ONE_Q16 - 1));
        // neighbor past the last column or row is clamped, its weight is zero
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
        return 1'b1;
    endfunction

    function automatic longint stored_pixel(input int x, input int y);
        return longint'(src_img[y * MAX_SRC_WIDTH + x]);
    endfunction

    // bilinear blend, truncated to 8 bits
    function automatic t_warp_result interpolate_pixel(input logic [DST_FW-1:0] dc, dr);
        int           x0, y0, x1, y1, fx, fy;
        longint       top, bottom, blend;
        t_warp_result res;
        res.pixel   = '0;
        res.outside = 1'b1;
        if (map_to_source(dc, dr, x0, y0, x1, y1, fx, fy)) begin
            top    = (ONE_Q16 - fx) * stored_pixel(x0, y0) + longint'(fx) * stored_pixel(x1, y0);
            bottom = (ONE_Q16 - fx) * stored_pixel(x0, y1) + longint'(fx) * stored_pixel(x1, y1);
            blend  = (ONE_Q16 - fy) * top + longint'(fy) * bottom;
            res.pixel   = PIX_W'(blend >>> 32);
            res.outside = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [COEF_W-1:0] rand_q16(input int span);
        return COEF_W'($urandom_range(0, 2 * span)) - COEF_W'(span);
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef_extreme();
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            5: return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [DIM_REG_W-1:0] pick_dim_extreme();
        case ($urandom_range(0, 4))
            0: return 10'd0;
            1: return 10'd1;
            2: return 10'd2;
            3: return 10'd512;
            default: return 10'd1023;
        endcase
    endfunction

    // send one item and update the prediction when it is accepted
    task automatic send_item(input t_func kind, input logic [SRC_COL_FW-1:0] sc,
            input logic [SRC_ROW_FW-1:0] sr, input logic [PIX_W-1:0] pv,
            input logic [DST_FW-1:0] dc, input logic [DST_FW-1:0] dr);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word = '0;
        word[SRC_COL_FW-1:0]        = sc;
        word[OFS_SRC_ROW +: SRC_ROW_FW] = sr;
        word[OFS_PIX +: PIX_W]      = pv;
        word[OFS_DST_COL +: DST_FW] = dc;
        word[OFS_DST_ROW +: DST_FW] = dr;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        if (kind == FUNC_WRITE) begin
            src_img[int'(sr) * MAX_SRC_WIDTH + int'(sc)]     = pv;
            pix_written[int'(sr) * MAX_SRC_WIDTH + int'(sc)] = 1'b1;
            writes_sent++;
        end else begin
            warped_q.push_back(interpolate_pixel(dc, dr));
            samples_sent++;
        end
    endtask

    task automatic write_pixel(input int x, input int y, input logic [PIX_W-1:0] value);
        send_item(FUNC_WRITE, SRC_COL_FW'(x), SRC_ROW_FW'(y), value,
                  DST_FW'($urandom), DST_FW'($urandom));
    endtask

    task automatic fill_pixel(input int x, input int y);
        if (!pix_written[y * MAX_SRC_WIDTH + x])
            write_pixel(x, y, PIX_W'($urandom));
    endtask

    // sample a destination point, first writing any neighbor not yet stored
    task automatic sample_at(input logic [DST_FW-1:0] dc, input logic [DST_FW-1:0] dr);
        int x0, y0, x1, y1, fx, fy;
        if (map_to_source(dc, dr, x0, y0, x1, y1, fx, fy)) begin
            fill_pixel(x0, y0);
            fill_pixel(x1, y0);
            fill_pixel(x0, y1);
            fill_pixel(x1, y1);
        end
        send_item(FUNC_SAMPLE, SRC_COL_FW'($urandom), SRC_ROW_FW'($urandom),
                  PIX_W'($urandom), dc, dr);
    endtask

    // stop sending and let the pipe empty
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (warped_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [COEF_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_SOURCE_WIDTH || idx == REG_SOURCE_HEIGHT)
            warp_regs[idx] = {{(COEF_W-DIM_REG_W){1'b0}}, value[DIM_REG_W-1:0]};
        else
            warp_regs[idx] = value;
    endtask

    // write all eight registers; upper bits of the size words are junk
    task automatic load_transform(input logic [COEF_W-1:0] cx, rx, ox, cy, ry, oy,
            input logic [DIM_REG_W-1:0] wd, input logic [DIM_REG_W-1:0] ht);
        write_reg(REG_COEF_COL_TO_X, cx);
        write_reg(REG_COEF_ROW_TO_X, rx);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_COEF_COL_TO_Y, cy);
        write_reg(REG_COEF_ROW_TO_Y, ry);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_SOURCE_WIDTH, {(COEF_W-DIM_REG_W)'($urandom), wd});
        write_reg(REG_SOURCE_HEIGHT, {(COEF_W-DIM_REG_W)'($urandom), ht});
        i_cfg_valid <= 1'b0;
        transforms_loaded++;
    endtask

    // reset transform: identity over a full 512 x 512 image, corners and off-image
    task automatic test_reset_identity();
        write_pixel(0, 0, 8'hFF);
        write_pixel(511, 511, 8'h00);
        write_pixel(511, 0, 8'hA5);
        write_pixel(0, 511, 8'h5A);
        sample_at(10'd0, 10'd0);
        sample_at(10'd511, 10'd511);
        sample_at(10'd511, 10'd0);
        sample_at(10'd0, 10'd511);
        sample_at(10'd1023, 10'd1023);
        sample_at(10'd1023, 10'd0);
        sample_at(10'd0, 10'd1023);
    endtask

    // exact right and bottom edges, one pixel past both, y at bottom + 1 - lsb, x one lsb below zero
    task automatic test_edge_bounds();
        drain_results();
        load_transform(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
                       10'd5, 10'd4);
        sample_at(10'd4, 10'd3);
        sample_at(10'd5, 10'd3);
        sample_at(10'd4, 10'd4);
        sample_at(10'd2, 10'd1);
        drain_results();
        load_transform(COEF_ONE, COEF_ZERO, 32'hFFFF_FFFF, COEF_ZERO, COEF_ONE, 32'h0000_FFFF,
                       10'd5, 10'd4);
        sample_at(10'd0, 10'd0);
        sample_at(10'd1, 10'd0);
        sample_at(10'd4, 10'd0);
        sample_at(10'd1, 10'd3);
    endtask

    // fractional weights with mixed-sign coefficients
    task automatic test_fractional_blend();
        drain_results();
        load_transform(32'h0000_8000, 32'h0000_1000, 32'h0000_2345,
                       32'hFFFF_F000, 32'h0000_C000, 32'h0000_4000, 10'd6, 10'd5);
        sample_at(10'd0, 10'd0);
        sample_at(10'd3, 10'd2);
        sample_at(10'd5, 10'd4);
        sample_at(10'd9, 10'd3);
    endtask

    // size registers below 2 and above the store limit
    task automatic test_size_saturation();
        drain_results();
        load_transform(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
                       10'd0, 10'd1023);
        sample_at(10'd1, 10'd511);
        sample_at(10'd2, 10'd0);
        drain_results();
        load_transform(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
                       10'd513, 10'd1);
        sample_at(10'd511, 10'd1);
        sample_at(10'd0, 10'd2);
    endtask

    // long output stall with the sender pushing, then a full pause on the input
    task automatic test_output_backpressure();
        drain_results();
        load_transform(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
                       10'd8, 10'd8);
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        sink_hold = LONG_HOLD;
        repeat (60)
            sample_at(DST_FW'($urandom_range(0, 9)), DST_FW'($urandom_range(0, 9)));
        drain_results();
        src_idle = 1'b1;
        repeat (20)
            sample_at(DST_FW'($urandom_range(0, 9)), DST_FW'($urandom_range(0, 9)));
    endtask

    // one random transform, then a burst of mostly samples
    task automatic run_random_phase();
        t_phase_kind          kind;
        int                   w, h, dst_hi;
        logic [COEF_W-1:0]    cx, rx, ox, cy, ry, oy;
        logic [DIM_REG_W-1:0] wd, ht;
        kind = t_phase_kind'($urandom_range(0, 3));
        case (kind)
            PH_SMALL: begin
                w  = $urandom_range(2, 20);
                h  = $urandom_range(2, 20);
                wd = DIM_REG_W'(w);
                ht = DIM_REG_W'(h);
                cx = rand_q16(98304);
                rx = rand_q16(98304);
                cy = rand_q16(98304);
                ry = rand_q16(98304);
                ox = COEF_W'($urandom_range(0, (w + 1) * 65536)) - COEF_W'(65536);
                oy = COEF_W'($urandom_range(0, (h + 1) * 65536)) - COEF_W'(65536);
                dst_hi = 31;
            end
            PH_WIDE: begin
                w  = $urandom_range(2, MAX_SRC_WIDTH);
                h  = $urandom_range(2, MAX_SRC_HEIGHT);
                wd = DIM_REG_W'(w);
                ht = DIM_REG_W'(h);
                cx = rand_q16(131072);
                rx = rand_q16(131072);
                cy = rand_q16(131072);
                ry = rand_q16(131072);
                ox = COEF_W'($urandom_range(0, w * 65536));
                oy = COEF_W'($urandom_range(0, h * 65536));
                dst_hi = MAX_DST_DIM - 1;
            end
            PH_WILD: begin
                cx = $urandom;
                rx = $urandom;
                ox = $urandom;
                cy = $urandom;
                ry = $urandom;
                oy = $urandom;
                wd = DIM_REG_W'($urandom);
                ht = DIM_REG_W'($urandom);
                dst_hi = MAX_DST_DIM - 1;
            end
            default: begin
                cx = pick_coef_extreme();
                rx = pick_coef_extreme();
                ox = pick_coef_extreme();
                cy = pick_coef_extreme();
                ry = pick_coef_extreme();
                oy = pick_coef_extreme();
                wd = pick_dim_extreme();
                ht = pick_dim_extreme();
                dst_hi = MAX_DST_DIM - 1;
            end
        endcase
        drain_results();
        load_transform(cx, rx, ox, cy, ry, oy, wd, ht);
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        repeat (PHASE_ITEMS) begin
            if (items_sent >= ITEM_TARGET)
                break;
            if ($urandom_range(0, 4) == 0)
                write_pixel($urandom_range(0, MAX_SRC_WIDTH - 1),
                            $urandom_range(0, MAX_SRC_HEIGHT - 1), PIX_W'($urandom));
            else
                sample_at(DST_FW'($urandom_range(0, dst_hi)),
                          DST_FW'($urandom_range(0, dst_hi)));
        end
    endtask

    task automatic test_random_phases();
        while (items_sent < ITEM_TARGET)
            run_random_phase();
    endtask

    // result side: random ready gaps and the occasional long hold
    initial begin : result_sink
        int pause;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                pause     = sink_hold;
                sink_hold = 0;
            end else begin
                pause = sink_idle ? $urandom_range(0, 7) : 0;
            end
            if (pause > 0) begin
                i_m_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_warp_result want;
        cycle_cnt++;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (warped_q.size() == 0) begin
                err_cnt++;
                $display("%0t: result with none expected, pixel_out %0d outside %0b",
                         $time, o_m_tdata, o_m_tuser);
            end else begin
                want = warped_q.pop_front();
                results_seen++;
                if (!want.outside)
                    inside_seen++;
                if (o_m_tdata !== want.pixel) begin
                    err_cnt++;
                    $display("%0t: pixel_out expected %0d, got %0d",
                             $time, want.pixel, o_m_tdata);
                end
                if (o_m_tuser !== want.outside) begin
                    err_cnt++;
                    $display("%0t: outside expected %0b, got %0b",
                             $time, want.outside, o_m_tuser);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, warped_q.size());
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= FUNC_WRITE;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_COEF_COL_TO_X;
        i_cfg_data  <= '0;
        warp_regs[REG_COEF_COL_TO_X] = COEF_ONE;
        warp_regs[REG_COEF_ROW_TO_X] = COEF_ZERO;
        warp_regs[REG_OFFSET_X]      = COEF_ZERO;
        warp_regs[REG_COEF_COL_TO_Y] = COEF_ZERO;
        warp_regs[REG_COEF_ROW_TO_Y] = COEF_ONE;
        warp_regs[REG_OFFSET_Y]      = COEF_ZERO;
        warp_regs[REG_SOURCE_WIDTH]  = COEF_W'(DIM_RST);
        warp_regs[REG_SOURCE_HEIGHT] = COEF_W'(DIM_RST);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_identity();
        test_edge_bounds();
        test_fractional_blend();
        test_size_saturation();
        test_output_backpressure();
        test_random_phases();

        drain_results();
        if (warped_q.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d predicted results never arrived", $time, warped_q.size());
        end
        $display("sent %0d items: %0d pixel writes and %0d samples over %0d transforms",
                 items_sent, writes_sent, samples_sent, transforms_loaded);
        $display("checked %0d results, %0d inside the source image, %0d mismatches",
                 results_seen, inside_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* affine_warp_bilinear_sampler_unit.f */
rtl/awbs_pkg.sv
rtl/awbs_ram.sv
rtl/affine_warp_bilinear_sampler_unit.sv
rtl/awbs_chk.sv
bench/tb_top.sv
